// ----- rtl/core/u8idv_pkg.sv -----
// Shared types and constants for the UTF-8 identifier validator.
// No dependencies; used by u8idv_check and utf8_identifier_validator.
`default_nettype none

package u8idv_pkg;

    // Identifier length limit; length of ID_SIZE bytes or more is an error
    localparam logic [7:0] ID_SIZE = 8'd128;
    localparam logic [7:0] COUNT_MAX = 8'hff;

    // Special second-byte limits selected by the lead byte
    localparam logic [2:0] LEAD_PLAIN = 3'd0;
    localparam logic [2:0] LEAD_E0    = 3'd1;
    localparam logic [2:0] LEAD_ED    = 3'd2;
    localparam logic [2:0] LEAD_F0    = 3'd3;
    localparam logic [2:0] LEAD_F4    = 3'd4;

    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DOT       = 8'h2e;
    localparam logic [7:0] CH_SLASH     = 8'h2f;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_DEL       = 8'h7f;

    localparam logic [7:0] LEAD2_LO = 8'hc2;
    localparam logic [7:0] LEAD2_HI = 8'hdf;
    localparam logic [7:0] LEAD3_LO = 8'he0;
    localparam logic [7:0] LEAD3_HI = 8'hef;
    localparam logic [7:0] LEAD4_LO = 8'hf0;
    localparam logic [7:0] LEAD4_HI = 8'hf4;
    localparam logic [7:0] BYTE_E0  = 8'he0;
    localparam logic [7:0] BYTE_ED  = 8'hed;
    localparam logic [7:0] BYTE_F0  = 8'hf0;
    localparam logic [7:0] BYTE_F4  = 8'hf4;
    localparam logic [7:0] SEC_A0   = 8'ha0;
    localparam logic [7:0] SEC_90   = 8'h90;

    // Decoder state carried from one byte to the next
    typedef struct packed {
        logic       error_seen;
        logic [1:0] cont_left;
        logic [2:0] lead_kind;
        logic       expect_second;
        logic [7:0] byte_count;
    } dec_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/u8idv_check.sv -----
// Per-byte rule check and next-state logic for the identifier validator.
// Depends on u8idv_pkg.
`default_nettype none

module u8idv_check (
    input  wire u8idv_pkg::dec_state_t state_cur,
    input  wire logic [7:0]            id_byte,
    input  wire logic                  last_byte,
    output u8idv_pkg::dec_state_t      state_next,
    output logic                       valid_so_far
);

    logic       err;
    logic [7:0] count_inc;
    logic [1:0] cont_nxt;
    logic [2:0] lead_nxt;
    logic       expect_nxt;

    always_comb
    begin
        err        = state_cur.error_seen;
        cont_nxt   = state_cur.cont_left;
        lead_nxt   = state_cur.lead_kind;
        expect_nxt = state_cur.expect_second;

        if ((state_cur.byte_count == 8'd0) &&
            ((id_byte == u8idv_pkg::CH_SPACE) || (id_byte == u8idv_pkg::CH_DOT)))
        begin
            err = 1'b1;
        end

        count_inc = (state_cur.byte_count == u8idv_pkg::COUNT_MAX) ?
                    u8idv_pkg::COUNT_MAX : state_cur.byte_count + 8'd1;
        if (count_inc >= u8idv_pkg::ID_SIZE)
        begin
            err = 1'b1;
        end

        if (state_cur.cont_left != 2'd0)
        begin
            if (id_byte[7:6] != 2'b10)
            begin
                err = 1'b1;
            end
            if (state_cur.expect_second)
            begin
                if (((state_cur.lead_kind == u8idv_pkg::LEAD_E0) &&
                     (id_byte < u8idv_pkg::SEC_A0)) ||
                    ((state_cur.lead_kind == u8idv_pkg::LEAD_ED) &&
                     (id_byte >= u8idv_pkg::SEC_A0)) ||
                    ((state_cur.lead_kind == u8idv_pkg::LEAD_F0) &&
                     (id_byte < u8idv_pkg::SEC_90)) ||
                    ((state_cur.lead_kind == u8idv_pkg::LEAD_F4) &&
                     (id_byte >= u8idv_pkg::SEC_90)))
                begin
                    err = 1'b1;
                end
                expect_nxt = 1'b0;
            end
            cont_nxt = state_cur.cont_left - 2'd1;
        end
        else
        begin
            lead_nxt = u8idv_pkg::LEAD_PLAIN;
            if (!id_byte[7])
            begin
                if ((id_byte < u8idv_pkg::CH_SPACE) || (id_byte == u8idv_pkg::CH_DEL) ||
                    (id_byte == u8idv_pkg::CH_SLASH) ||
                    (id_byte == u8idv_pkg::CH_BACKSLASH))
                begin
                    err = 1'b1;
                end
            end
            else if ((id_byte >= u8idv_pkg::LEAD2_LO) && (id_byte <= u8idv_pkg::LEAD2_HI))
            begin
                cont_nxt = 2'd1;
            end
            else if ((id_byte >= u8idv_pkg::LEAD3_LO) && (id_byte <= u8idv_pkg::LEAD3_HI))
            begin
                cont_nxt = 2'd2;
                if (id_byte == u8idv_pkg::BYTE_E0)
                begin
                    lead_nxt = u8idv_pkg::LEAD_E0;
                end
                else if (id_byte == u8idv_pkg::BYTE_ED)
                begin
                    lead_nxt = u8idv_pkg::LEAD_ED;
                end
            end
            else if ((id_byte >= u8idv_pkg::LEAD4_LO) && (id_byte <= u8idv_pkg::LEAD4_HI))
            begin
                cont_nxt = 2'd3;
                if (id_byte == u8idv_pkg::BYTE_F0)
                begin
                    lead_nxt = u8idv_pkg::LEAD_F0;
                end
                else if (id_byte == u8idv_pkg::BYTE_F4)
                begin
                    lead_nxt = u8idv_pkg::LEAD_F4;
                end
            end
            else
            begin
                err = 1'b1;
            end
            expect_nxt = (cont_nxt != 2'd0);
        end

        // trailing space and truncated sequence only count at the end
        if (last_byte && ((id_byte == u8idv_pkg::CH_SPACE) || (cont_nxt != 2'd0)))
        begin
            err = 1'b1;
        end

        valid_so_far = !err;

        if (last_byte)
        begin
            state_next = '0;
        end
        else
        begin
            state_next.error_seen    = err;
            state_next.cont_left     = cont_nxt;
            state_next.lead_kind     = lead_nxt;
            state_next.expect_second = expect_nxt;
            state_next.byte_count    = count_inc;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/utf8_identifier_validator.sv -----
// UTF-8 identifier validator: one result per byte, input register -> check -> result register.
// Throughput 1 byte per cycle while the result side accepts or has room.
// The decoder state update is the feedback loop that sets the rate.
// Both register stages move while the result side accepts or has room.
// Reset (rst_n low, asynchronous) empties both stages and clears the decoder state.
// Depends on u8idv_pkg and u8idv_check.
`default_nettype none

module utf8_identifier_validator (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] id_byte
    input  wire logic       s_tlast,   // last_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [0] valid_so_far, [7:1] zero
    output logic            m_tlast    // verdict_final
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    logic                  out_valid_reg;
    logic                  out_ok_reg;
    logic                  out_last_reg;
    u8idv_pkg::dec_state_t state_reg;
    u8idv_pkg::dec_state_t state_next;
    logic                  ok_next;
    logic                  advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    u8idv_check u_check (
        .state_cur    (state_reg),
        .id_byte      (in_byte_reg),
        .last_byte    (in_last_reg),
        .state_next   (state_next),
        .valid_so_far (ok_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance)
        begin
            out_ok_reg   <= ok_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_ok_reg};
    assign m_tlast  = out_last_reg;

    // state clears after the last byte of an identifier is checked
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (state_reg == '0))
        else $error("decoder state not cleared after last byte");

    // a recorded error sticks into the next verdict
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && state_reg.error_seen) |=> !m_tdata[0])
        else $error("sticky error lost");

    // input side only stalls when both stages are full and the output is blocked
    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without backpressure");

    // a continuation count of zero never expects a second byte
    a_expect_cont: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.expect_second |-> (state_reg.cont_left != 2'd0))
        else $error("second-byte flag without open sequence");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for utf8_identifier_validator: streams identifiers and compares
// each verdict with a built-in predictor or a typed value. Depends on u8idv_pkg and the RTL.

module tb_top;
    import u8idv_pkg::*;

    typedef struct packed {
        logic ok;
        logic fin;
    } verdict_t;

    typedef struct {
        logic [7:0] byte_val;
        logic       is_last;
        bit         typed;
        logic       typed_ok;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] id_byte
    logic       s_tlast = 1'b0;    // last_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [0] valid_so_far, [7:1] zero
    logic       m_tlast;           // verdict_final

    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         bytes_sent = 0;
    int         mismatch_count = 0;
    verdict_t   verdict_q[$];
    dec_state_t id_state = '0;

    dir_row_t directed_rows [24] = '{
        '{8'h00, 1'b1, 1'b1, 1'b0},   // zero byte alone
        '{8'h20, 1'b0, 1'b1, 1'b0},   // leading space
        '{8'h61, 1'b1, 1'b1, 1'b0},   // error sticks to the end
        '{8'h2e, 1'b1, 1'b1, 1'b0},   // leading dot
        '{8'h41, 1'b0, 1'b1, 1'b1},
        '{8'h20, 1'b0, 1'b1, 1'b1},   // inner space is fine so far
        '{8'h20, 1'b1, 1'b1, 1'b0},   // trailing space
        '{8'he0, 1'b0, 1'b0, 1'b0},
        '{8'ha0, 1'b0, 1'b0, 1'b0},
        '{8'h80, 1'b1, 1'b0, 1'b0},
        '{8'hed, 1'b0, 1'b0, 1'b0},
        '{8'ha0, 1'b1, 1'b0, 1'b0},   // surrogate range, cut short
        '{8'hf0, 1'b0, 1'b0, 1'b0},
        '{8'h8f, 1'b0, 1'b0, 1'b0},   // overlong four-byte form
        '{8'h80, 1'b0, 1'b0, 1'b0},
        '{8'h80, 1'b1, 1'b0, 1'b0},
        '{8'hf4, 1'b0, 1'b0, 1'b0},
        '{8'h8f, 1'b0, 1'b0, 1'b0},
        '{8'hbf, 1'b0, 1'b0, 1'b0},
        '{8'hbf, 1'b1, 1'b0, 1'b0},
        '{8'hc2, 1'b0, 1'b0, 1'b0},
        '{8'h7f, 1'b1, 1'b0, 1'b0},   // DEL where a continuation is owed
        '{8'hff, 1'b1, 1'b1, 1'b0},
        '{8'h5c, 1'b1, 1'b1, 1'b0}
    };

    int long_len [3] = '{127, 128, 257};

    utf8_identifier_validator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Running verdict for one byte; updates the decoder state
    function automatic verdict_t judge_byte(input logic [7:0] b, input logic fin);
        logic       bad;
        logic [7:0] cnt;
        verdict_t   v;
        bad = id_state.error_seen;
        cnt = id_state.byte_count;
        if (cnt == 8'd0 && (b == CH_SPACE || b == CH_DOT))
            bad = 1'b1;
        if (cnt != COUNT_MAX)
            cnt = cnt + 8'd1;
        if (cnt >= ID_SIZE)
            bad = 1'b1;
        if (id_state.cont_left != 2'd0)
        begin
            if (b[7:6] != 2'b10)
                bad = 1'b1;
            if (id_state.expect_second)
            begin
                case (id_state.lead_kind)
                    LEAD_E0: if (b < SEC_A0) bad = 1'b1;
                    LEAD_ED: if (b >= SEC_A0) bad = 1'b1;
                    LEAD_F0: if (b < SEC_90) bad = 1'b1;
                    LEAD_F4: if (b >= SEC_90) bad = 1'b1;
                    default: ;
                endcase
                id_state.expect_second = 1'b0;
            end
            id_state.cont_left = id_state.cont_left - 2'd1;
        end
        else
        begin
            id_state.lead_kind = LEAD_PLAIN;
            if (!b[7])
            begin
                if (b < CH_SPACE || b == CH_DEL || b == CH_SLASH || b == CH_BACKSLASH)
                    bad = 1'b1;
            end
            else if (b >= LEAD2_LO && b <= LEAD2_HI)
                id_state.cont_left = 2'd1;
            else if (b >= LEAD3_LO && b <= LEAD3_HI)
            begin
                id_state.cont_left = 2'd2;
                if (b == BYTE_E0)
                    id_state.lead_kind = LEAD_E0;
                else if (b == BYTE_ED)
                    id_state.lead_kind = LEAD_ED;
            end
            else if (b >= LEAD4_LO && b <= LEAD4_HI)
            begin
                id_state.cont_left = 2'd3;
                if (b == BYTE_F0)
                    id_state.lead_kind = LEAD_F0;
                else if (b == BYTE_F4)
                    id_state.lead_kind = LEAD_F4;
            end
            else
                bad = 1'b1;
            id_state.expect_second = (id_state.cont_left != 2'd0);
        end
        if (fin && (b == CH_SPACE || id_state.cont_left != 2'd0))
            bad = 1'b1;
        v.ok = ~bad;
        v.fin = fin;
        if (fin)
            id_state = '0;
        else
        begin
            id_state.error_seen = bad;
            id_state.byte_count = cnt;
        end
        return v;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin, input bit use_typed,
                             input logic typed_ok);
        verdict_t v;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= fin;
        do @(posedge clk); while (!s_tready);
        v = judge_byte(b, fin);
        if (use_typed)
            v.ok = typed_ok;
        verdict_q.push_back(v);
        bytes_sent++;
    endtask

    // Hold the sender off until every pending verdict has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_char(ref logic [7:0] ident[$]);
        int         kind;
        logic [7:0] lead;
        kind = $urandom_range(99);
        if (kind < 40)
        begin
            lead = 8'($urandom_range(8'h21, 8'h7e));
            if (lead == CH_SLASH || lead == CH_BACKSLASH)
                lead = 8'h5f;
            ident.push_back(lead);
        end
        else if (kind < 45)
            ident.push_back(CH_SPACE);
        else if (kind < 65)
        begin
            ident.push_back(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
            ident.push_back(8'($urandom_range(8'h80, 8'hbf)));
        end
        else if (kind < 85)
        begin
            lead = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
            ident.push_back(lead);
            if (lead == BYTE_E0)
                ident.push_back(8'($urandom_range(SEC_A0, 8'hbf)));
            else if (lead == BYTE_ED)
                ident.push_back(8'($urandom_range(8'h80, 8'h9f)));
            else
                ident.push_back(8'($urandom_range(8'h80, 8'hbf)));
            ident.push_back(8'($urandom_range(8'h80, 8'hbf)));
        end
        else
        begin
            lead = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
            ident.push_back(lead);
            if (lead == BYTE_F0)
                ident.push_back(8'($urandom_range(SEC_90, 8'hbf)));
            else if (lead == BYTE_F4)
                ident.push_back(8'($urandom_range(8'h80, 8'h8f)));
            else
                ident.push_back(8'($urandom_range(8'h80, 8'hbf)));
            ident.push_back(8'($urandom_range(8'h80, 8'hbf)));
            ident.push_back(8'($urandom_range(8'h80, 8'hbf)));
        end
    endtask

    // Mostly well-formed identifiers; some damaged, some pure noise
    task automatic send_random_ident();
        logic [7:0] ident[$];
        int         mode;
        int         nchars;
        mode = $urandom_range(99);
        if (mode < 85)
        begin
            nchars = $urandom_range(1, 8);
            repeat (nchars) add_char(ident);
            if (mode >= 70)
            begin
                if (ident.size() > 1 && $urandom_range(1) == 1)
                    void'(ident.pop_back());
                else
                    ident[$urandom_range(ident.size() - 1)] = 8'($urandom_range(255));
            end
        end
        else
        begin
            nchars = $urandom_range(1, 8);
            repeat (nchars) ident.push_back(8'($urandom_range(255)));
        end
        for (int i = 0; i < ident.size(); i++)
            send_byte(ident[i], i == ident.size() - 1, 1'b0, 1'b0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("unexpected transfer: valid_so_far %0d verdict_final %0d",
                       m_tdata[0], m_tlast);
                mismatch_count++;
            end
            else
            begin
                verdict_t v;
                v = verdict_q.pop_front();
                if (m_tdata[0] !== v.ok)
                begin
                    $error("valid_so_far: expected %0d, got %0d", v.ok, m_tdata[0]);
                    mismatch_count++;
                end
                if (m_tlast !== v.fin)
                begin
                    $error("verdict_final: expected %0d, got %0d", v.fin, m_tlast);
                    mismatch_count++;
                end
                if (m_tdata[7:1] !== 7'd0)
                begin
                    $error("tdata pad: expected 0, got %0h", m_tdata[7:1]);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].byte_val, directed_rows[i].is_last,
                      directed_rows[i].typed, directed_rows[i].typed_ok);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            // length limit: one below, exactly at, and past counter saturation
            if (phase < 3)
                for (int i = 0; i < long_len[phase]; i++)
                    send_byte(8'h61 + 8'($urandom_range(25)), i == long_len[phase] - 1,
                              1'b0, 1'b0);
            while (bytes_sent < (phase + 1) * 1050 / 4)
                send_random_ident();
            drain();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
